// ===== design/dht_pkg.sv =====
// Shared constants, types and width helpers for the disk hit/toggle/select block.
package dht_pkg;

  // Field widths of the transaction payloads and the configuration port
  localparam int OP_W       = 2;
  localparam int IDX_W      = 6;
  localparam int POS_W      = 16;
  localparam int RAD_W      = 15;
  localparam int CNT_W      = 7;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_DISKS  = 64;
  localparam int DEF_COORD_BITS = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLICK = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DISK_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_MODE = 2'd1;

  // Radius modes
  localparam logic [MODE_W-1:0] MODE_SHARED   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PER_DISK = 2'd2;

  // Address width of the disk table
  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Width of a counter that can also hold the depth itself
  function automatic int cnt_w(input int depth);
    return $clog2(depth + 1);
  endfunction

  // Operand width of the shared squarer (coordinate difference or radius)
  function automatic int sq_w(input int coord_bits);
    return (coord_bits + 1 > RAD_W) ? coord_bits + 1 : RAD_W;
  endfunction

  // Control of the disk and selection stores
  typedef struct packed {
    logic rd_en;
    logic disk_we;
    logic sel_we;
    logic sel_wdata;
    logic clr_en;
  } store_ctl_t;

  // Control of the shared squarer and accumulator
  typedef struct packed {
    logic sq_en;
    logic acc_load;
    logic acc_add;
  } arith_ctl_t;

endpackage

// ===== design/dht_ifs.sv =====
// Valid/ready channel interfaces for input and result transactions.
interface dht_in_if;
  logic                          valid;
  logic                          ready;
  logic [dht_pkg::OP_W-1:0]      op;
  logic [dht_pkg::IDX_W-1:0]     disk_index;
  logic signed [dht_pkg::POS_W-1:0] pos_x;
  logic signed [dht_pkg::POS_W-1:0] pos_y;
  logic [dht_pkg::RAD_W-1:0]     disk_radius;

  modport source (output valid, op, disk_index, pos_x, pos_y, disk_radius, input ready);
  modport sink   (input valid, op, disk_index, pos_x, pos_y, disk_radius, output ready);
endinterface

interface dht_out_if;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic [dht_pkg::IDX_W-1:0] hit_index;
  logic                      selected;

  modport source (output valid, hit, hit_index, selected, input ready);
  modport sink   (input valid, hit, hit_index, selected, output ready);
endinterface

// ===== design/dht_store.sv =====
// Disk table memory, selection bit memory and per-entry selection valid bits.
module dht_store #(
  parameter int MAX_DISKS  = dht_pkg::DEF_MAX_DISKS,
  parameter int COORD_BITS = dht_pkg::DEF_COORD_BITS
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  dht_pkg::store_ctl_t                       ctl,
  input  logic [dht_pkg::addr_w(MAX_DISKS)-1:0]     addr,
  input  logic [COORD_BITS-1:0]                     wr_cx,
  input  logic [COORD_BITS-1:0]                     wr_cy,
  input  logic [dht_pkg::RAD_W-1:0]                 wr_rad,
  input  logic [dht_pkg::cnt_w(MAX_DISKS)-1:0]      clr_n,
  output logic [COORD_BITS-1:0]                     rd_cx,
  output logic [COORD_BITS-1:0]                     rd_cy,
  output logic [dht_pkg::RAD_W-1:0]                 rd_rad,
  output logic                                      sel_eff
);

  localparam int DW = 2 * COORD_BITS + dht_pkg::RAD_W;

  logic [DW-1:0]        disk_mem [MAX_DISKS];
  logic                 sel_mem  [MAX_DISKS];
  logic [DW-1:0]        disk_q_r;
  logic                 sel_q_r;
  logic                 vld_q_r;
  logic [MAX_DISKS-1:0] vld_r;
  logic [MAX_DISKS-1:0] vld_nxt;

  // Disk table: one write and one registered read per cycle, both at addr
  always_ff @(posedge clk) begin
    if (ctl.disk_we) begin
      disk_mem[addr] <= {wr_cx, wr_cy, wr_rad};
    end
    if (ctl.rd_en) begin
      disk_q_r <= disk_mem[addr];
    end
  end

  // Selection bits; content counts only where the valid bit is set
  always_ff @(posedge clk) begin
    if (ctl.sel_we) begin
      sel_mem[addr] <= ctl.sel_wdata;
    end
    if (ctl.rd_en) begin
      sel_q_r <= sel_mem[addr];
      vld_q_r <= vld_r[addr];
    end
  end

  // Valid bits: set on a selection write, cleared at and beyond a new count
  always_comb begin
    vld_nxt = vld_r;
    if (ctl.sel_we) begin
      vld_nxt[addr] = 1'b1;
    end
    if (ctl.clr_en) begin
      for (int i = 0; i < MAX_DISKS; i++) begin
        if (i >= int'(clr_n)) begin
          vld_nxt[i] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign rd_cx   = disk_q_r[DW-1 -: COORD_BITS];
  assign rd_cy   = disk_q_r[dht_pkg::RAD_W +: COORD_BITS];
  assign rd_rad  = disk_q_r[dht_pkg::RAD_W-1:0];
  assign sel_eff = sel_q_r & vld_q_r;

endmodule

// ===== design/dht_arith.sv =====
// Shared squarer with registered product, distance accumulator and compare.
module dht_arith #(
  parameter int SQW = dht_pkg::sq_w(dht_pkg::DEF_COORD_BITS)
) (
  input  logic                clk,
  input  dht_pkg::arith_ctl_t ctl,
  input  logic [SQW-1:0]      operand,
  output logic                lt
);

  localparam int PW  = 2 * SQW;
  localparam int ACW = PW + 1;

  logic [PW-1:0]  prod_r;
  logic [ACW-1:0] acc_r;

  // One square per cycle, registered before use; the accumulator loads or adds the registered product
  always_ff @(posedge clk) begin
    if (ctl.sq_en) begin
      prod_r <= operand * operand;
    end
    if (ctl.acc_load) begin
      acc_r <= {1'b0, prod_r};
    end else if (ctl.acc_add) begin
      acc_r <= acc_r + {1'b0, prod_r};
    end
  end

  // Squared distance strictly below squared radius
  assign lt = acc_r < {1'b0, prod_r};

endmodule

// ===== design/disk_hit_toggle_select.sv =====
// Top level: sequencer for load, click and read transactions over the disk table.
//
// Usage: input transactions arrive on in_ch (op, disk_index, pos_x, pos_y,
// disk_radius); each produces exactly one result transaction on out_ch (hit,
// hit_index, selected). Registers disk_count and radius_mode are written over
// the cfg_ port (cfg_we, cfg_index, cfg_wdata); the user must write them only
// while no transaction is open, which the block itself does not enforce.
// in_ch.ready is high only while the sequencer is idle; one item is worked on
// at a time. A load, a spare op or a click with nothing to scan goes straight
// to the finish state; a read makes one memory read first; a click tests the
// disks in turn up to the first hit, each with one memory read and three
// passes through the single squarer (dx^2, dy^2, r^2) followed by a compare.
// The sequencer goes back to idle as the finish state loads the output register.
// A finished result waits in the output register while out_ch.ready is low;
// the next item is accepted meanwhile and holds its result until the output
// register frees up. Synchronous reset clears the registers, the selection
// bits (through their valid bits) and the sequencer; the disk table itself
// is not cleared and an entry must be loaded before a click tests it.
module disk_hit_toggle_select #(
  parameter int MAX_DISKS  = dht_pkg::DEF_MAX_DISKS,
  parameter int COORD_BITS = dht_pkg::DEF_COORD_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  dht_in_if.sink                           in_ch,
  dht_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [dht_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dht_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW   = dht_pkg::addr_w(MAX_DISKS);
  localparam int NW   = dht_pkg::cnt_w(MAX_DISKS);
  localparam int SQW  = dht_pkg::sq_w(COORD_BITS);
  localparam int EXTW = (COORD_BITS > dht_pkg::POS_W) ? COORD_BITS : dht_pkg::POS_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_RSEL = 3'd2;
  localparam logic [2:0] ST_SX   = 3'd3;
  localparam logic [2:0] ST_SY   = 3'd4;
  localparam logic [2:0] ST_SR   = 3'd5;
  localparam logic [2:0] ST_CMP  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0]                  state_r, state_nxt;
  logic [dht_pkg::CNT_W-1:0]   count_r;
  logic [dht_pkg::MODE_W-1:0]  mode_r;
  logic [NW-1:0]               n_act;
  logic [NW-1:0]               clr_n;

  logic [dht_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [dht_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [COORD_BITS-1:0]       px_r, px_nxt;
  logic [COORD_BITS-1:0]       py_r, py_nxt;
  logic [NW-1:0]               scan_r, scan_nxt;
  logic [dht_pkg::RAD_W-1:0]   rad0_r, rad0_nxt;

  logic                        res_hit_r, res_hit_nxt;
  logic [dht_pkg::IDX_W-1:0]   res_idx_r, res_idx_nxt;
  logic                        res_sel_r, res_sel_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_hit_r, out_hit_nxt;
  logic [dht_pkg::IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic                        out_sel_r, out_sel_nxt;

  logic                        in_acc;
  logic [EXTW-1:0]             ext_x, ext_y;
  logic [COORD_BITS-1:0]       in_cx, in_cy;

  dht_pkg::store_ctl_t         st_ctl;
  dht_pkg::arith_ctl_t         ar_ctl;
  logic [AW-1:0]               st_addr;
  logic [AW-1:0]               scan_addr;
  logic [COORD_BITS-1:0]       rd_cx, rd_cy;
  logic [dht_pkg::RAD_W-1:0]   rd_rad;
  logic                        sel_eff;
  logic                        lt;

  logic signed [COORD_BITS:0]  dx, dy;
  logic [COORD_BITS:0]         dx_abs, dy_abs;
  logic [dht_pkg::RAD_W-1:0]   rad_use;
  logic [SQW-1:0]              operand;
  logic                        read_ok;

  // Handshake
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.hit       = out_hit_r;
  assign out_ch.hit_index = out_idx_r;
  assign out_ch.selected  = out_sel_r;

  // Coordinates: low COORD_BITS bits of the field, two's complement
  assign ext_x = EXTW'($unsigned(in_ch.pos_x));
  assign ext_y = EXTW'($unsigned(in_ch.pos_y));
  assign in_cx = ext_x[COORD_BITS-1:0];
  assign in_cy = ext_y[COORD_BITS-1:0];

  // Active disk count, clamped to the table depth
  assign n_act = (32'(count_r) > MAX_DISKS) ? NW'(MAX_DISKS) : NW'(count_r);
  assign clr_n = (32'(cfg_wdata[dht_pkg::CNT_W-1:0]) > MAX_DISKS) ? NW'(MAX_DISKS)
               : NW'(cfg_wdata[dht_pkg::CNT_W-1:0]);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mode_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dht_pkg::REG_DISK_COUNT:  count_r <= cfg_wdata[dht_pkg::CNT_W-1:0];
        dht_pkg::REG_RADIUS_MODE: mode_r  <= cfg_wdata[dht_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Operand selection for the shared squarer
  assign scan_addr = scan_r[AW-1:0];
  assign dx      = $signed({px_r[COORD_BITS-1], px_r}) - $signed({rd_cx[COORD_BITS-1], rd_cx});
  assign dy      = $signed({py_r[COORD_BITS-1], py_r}) - $signed({rd_cy[COORD_BITS-1], rd_cy});
  assign dx_abs  = dx[COORD_BITS] ? $unsigned(-dx) : $unsigned(dx);
  assign dy_abs  = dy[COORD_BITS] ? $unsigned(-dy) : $unsigned(dy);
  assign rad_use = (mode_r == dht_pkg::MODE_SHARED && scan_r != '0) ? rad0_r : rd_rad;
  assign read_ok = (32'(idx_r) < MAX_DISKS) && (32'(idx_r) < 32'(n_act));

  always_comb begin
    case (state_r)
      ST_SX:   operand = SQW'(dx_abs);
      ST_SY:   operand = SQW'(dy_abs);
      default: operand = SQW'(rad_use);
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    idx_nxt     = idx_r;
    px_nxt      = px_r;
    py_nxt      = py_r;
    scan_nxt    = scan_r;
    rad0_nxt    = rad0_r;
    res_hit_nxt = res_hit_r;
    res_idx_nxt = res_idx_r;
    res_sel_nxt = res_sel_r;
    st_ctl      = '0;
    ar_ctl      = '0;
    st_addr     = scan_addr;

    st_ctl.clr_en = cfg_we && (cfg_index == dht_pkg::REG_DISK_COUNT);

    // Result register: drains on the receiver's ready, refills from FIN
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_hit_nxt   = out_hit_r;
    out_idx_nxt   = out_idx_r;
    out_sel_nxt   = out_sel_r;

    case (state_r)
      ST_IDLE: begin
        st_addr = AW'(in_ch.disk_index);
        if (in_acc) begin
          op_nxt      = in_ch.op;
          idx_nxt     = in_ch.disk_index;
          px_nxt      = in_cx;
          py_nxt      = in_cy;
          scan_nxt    = '0;
          res_hit_nxt = 1'b0;
          res_idx_nxt = '0;
          res_sel_nxt = 1'b0;
          case (in_ch.op)
            dht_pkg::OP_LOAD: begin
              st_ctl.disk_we = (32'(in_ch.disk_index) < MAX_DISKS);
              state_nxt      = ST_FIN;
            end
            dht_pkg::OP_CLICK: begin
              if (mode_r inside {dht_pkg::MODE_SHARED, dht_pkg::MODE_PER_DISK}
                  && n_act != '0) begin
                state_nxt = ST_RD;
              end else begin
                state_nxt = ST_FIN;
              end
            end
            dht_pkg::OP_READ: state_nxt = ST_RD;
            default:          state_nxt = ST_FIN;
          endcase
        end
      end
      ST_RD: begin
        st_ctl.rd_en = 1'b1;
        if (op_r == dht_pkg::OP_CLICK) begin
          st_addr   = scan_addr;
          state_nxt = ST_SX;
        end else begin
          st_addr   = AW'(idx_r);
          state_nxt = ST_RSEL;
        end
      end
      ST_RSEL: begin
        res_sel_nxt = read_ok & sel_eff;
        state_nxt   = ST_FIN;
      end
      ST_SX: begin
        ar_ctl.sq_en = 1'b1;
        state_nxt    = ST_SY;
      end
      ST_SY: begin
        ar_ctl.sq_en    = 1'b1;
        ar_ctl.acc_load = 1'b1;
        state_nxt       = ST_SR;
      end
      ST_SR: begin
        ar_ctl.sq_en   = 1'b1;
        ar_ctl.acc_add = 1'b1;
        if (scan_r == '0) begin
          rad0_nxt = rd_rad;
        end
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (lt) begin
          // First hit: toggle its selection bit and stop the scan
          st_ctl.sel_we    = 1'b1;
          st_ctl.sel_wdata = ~sel_eff;
          res_hit_nxt      = 1'b1;
          res_idx_nxt      = dht_pkg::IDX_W'(scan_addr);
          res_sel_nxt      = ~sel_eff;
          state_nxt        = ST_FIN;
        end else if (NW'(scan_r + 1'b1) == n_act) begin
          state_nxt = ST_FIN;
        end else begin
          scan_nxt  = NW'(scan_r + 1'b1);
          state_nxt = ST_RD;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_idx_nxt   = res_idx_r;
          out_sel_nxt   = res_sel_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item, scan and result payload
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    idx_r     <= idx_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    scan_r    <= scan_nxt;
    rad0_r    <= rad0_nxt;
    res_hit_r <= res_hit_nxt;
    res_idx_r <= res_idx_nxt;
    res_sel_r <= res_sel_nxt;
    out_hit_r <= out_hit_nxt;
    out_idx_r <= out_idx_nxt;
    out_sel_r <= out_sel_nxt;
  end

  dht_store #(
    .MAX_DISKS  (MAX_DISKS),
    .COORD_BITS (COORD_BITS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (st_ctl),
    .addr    (st_addr),
    .wr_cx   (in_cx),
    .wr_cy   (in_cy),
    .wr_rad  (in_ch.disk_radius),
    .clr_n   (clr_n),
    .rd_cx   (rd_cx),
    .rd_cy   (rd_cy),
    .rd_rad  (rd_rad),
    .sel_eff (sel_eff)
  );

  dht_arith #(
    .SQW (SQW)
  ) u_arith (
    .clk     (clk),
    .ctl     (ar_ctl),
    .operand (operand),
    .lt      (lt)
  );

  // An accepted transaction always moves the sequencer out of idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != ST_IDLE)
    else $error("sequencer idle right after an accepted transaction");

  // The compare only follows the radius square
  a_cmp_after_sr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> $past(state_r) == ST_SR)
    else $error("compare entered without a full distance pass");

  // A result appears only out of the finish state
  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result register loaded outside the finish state");

endmodule

// ===== bench/tb_disk_hit_toggle_select.sv =====
// Testbench for disk_hit_toggle_select: directed table plus random phases, scoreboarded.
module tb_disk_hit_toggle_select;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NDISK = dht_pkg::DEF_MAX_DISKS;
  localparam int CYCLE_LIMIT = 1_000_000;

  // Codes the package leaves unnamed
  localparam logic [dht_pkg::OP_W-1:0]      OP_SPARE    = 2'd3;
  localparam logic [dht_pkg::MODE_W-1:0]    MODE_NONE   = 2'd0;
  localparam logic [dht_pkg::MODE_W-1:0]    MODE_SPARE  = 2'd3;
  localparam logic [dht_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [dht_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic                      hit;
    logic [dht_pkg::IDX_W-1:0] hit_index;
    logic                      selected;
  } disk_result_t;

  // One row of the directed table: either a register write or a transaction
  typedef struct {
    bit                               is_cfg;
    logic [dht_pkg::CFG_IDX_W-1:0]    reg_idx;
    logic [dht_pkg::CFG_DATA_W-1:0]   reg_data;
    logic [dht_pkg::OP_W-1:0]         op;
    logic [dht_pkg::IDX_W-1:0]        idx;
    logic signed [dht_pkg::POS_W-1:0] x;
    logic signed [dht_pkg::POS_W-1:0] y;
    logic [dht_pkg::RAD_W-1:0]        r;
    bit                               typed;
    disk_result_t                     want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic                           cfg_we;
  logic [dht_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dht_pkg::CFG_DATA_W-1:0] cfg_wdata;

  dht_in_if  in_ch();
  dht_out_if out_ch();

  disk_hit_toggle_select dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the disk table, selection bits and registers
  logic signed [dht_pkg::POS_W-1:0] disk_x [NDISK];
  logic signed [dht_pkg::POS_W-1:0] disk_y [NDISK];
  logic [dht_pkg::RAD_W-1:0]        disk_r [NDISK];
  bit                               disk_loaded [NDISK];
  bit                               sel_bits [NDISK];
  logic [dht_pkg::CNT_W-1:0]        shadow_count;
  logic [dht_pkg::MODE_W-1:0]       shadow_mode;

  disk_result_t hit_select_due [$];
  stim_row_t    directed [$];
  int mismatch_cnt = 0;
  int cycle_cnt = 0;
  int gap_pct;
  int stall_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int disks_in_use();
    return (shadow_count > NDISK) ? NDISK : int'(shadow_count);
  endfunction

  // Register write as seen by the shadow state
  function automatic void apply_reg(logic [dht_pkg::CFG_IDX_W-1:0] ridx,
                                    logic [dht_pkg::CFG_DATA_W-1:0] data);
    if (ridx == dht_pkg::REG_DISK_COUNT) begin
      shadow_count = data;
      for (int i = disks_in_use(); i < NDISK; i++) sel_bits[i] = 1'b0;
    end else if (ridx == dht_pkg::REG_RADIUS_MODE) begin
      shadow_mode = data[dht_pkg::MODE_W-1:0];
    end
  endfunction

  // Result of one transaction, updating the shadow table and selection bits
  function automatic disk_result_t predict_hit_select(
    logic [dht_pkg::OP_W-1:0] op, logic [dht_pkg::IDX_W-1:0] idx,
    logic signed [dht_pkg::POS_W-1:0] px, logic signed [dht_pkg::POS_W-1:0] py,
    logic [dht_pkg::RAD_W-1:0] r);
    disk_result_t res;
    longint dx, dy, rr;
    int n;
    res = '0;
    n = disks_in_use();
    case (op)
      dht_pkg::OP_LOAD: begin
        disk_x[idx] = px;
        disk_y[idx] = py;
        disk_r[idx] = r;
        disk_loaded[idx] = 1'b1;
      end
      dht_pkg::OP_CLICK: begin
        if (shadow_mode == dht_pkg::MODE_SHARED || shadow_mode == dht_pkg::MODE_PER_DISK) begin
          // first disk whose squared distance is strictly below the squared radius in use (disk 0's in shared mode)
          for (int i = 0; i < n && !res.hit; i++) begin
            rr = (shadow_mode == dht_pkg::MODE_SHARED) ? longint'(disk_r[0])
                                                        : longint'(disk_r[i]);
            dx = longint'(px) - longint'(disk_x[i]);
            dy = longint'(py) - longint'(disk_y[i]);
            if (dx * dx + dy * dy < rr * rr) begin
              sel_bits[i] = ~sel_bits[i];
              res.hit = 1'b1;
              res.hit_index = i[dht_pkg::IDX_W-1:0];
              res.selected = sel_bits[i];
            end
          end
        end
      end
      dht_pkg::OP_READ: begin
        if (int'(idx) < n) res.selected = sel_bits[idx];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [dht_pkg::RAD_W-1:0] pick_radius();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return dht_pkg::RAD_W'($urandom_range(1, 2000));
    if (p < 90) return dht_pkg::RAD_W'($urandom);
    return '0;
  endfunction

  function automatic stim_row_t cfg_row(logic [dht_pkg::CFG_IDX_W-1:0] ridx,
                                        logic [dht_pkg::CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.reg_idx = ridx;
    row.reg_data = data;
    return row;
  endfunction

  function automatic stim_row_t item_row(
    logic [dht_pkg::OP_W-1:0] op, logic [dht_pkg::IDX_W-1:0] idx,
    logic signed [dht_pkg::POS_W-1:0] x, logic signed [dht_pkg::POS_W-1:0] y,
    logic [dht_pkg::RAD_W-1:0] r,
    bit typed, logic hit, logic [dht_pkg::IDX_W-1:0] hidx, logic sel);
    stim_row_t row;
    row = '{default: '0};
    row.op = op;
    row.idx = idx;
    row.x = x;
    row.y = y;
    row.r = r;
    row.typed = typed;
    row.want = '{hit, hidx, sel};
    return row;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(stim_row_t row);
    directed.insert(directed.size(), row);
  endfunction

  // Register write, only once every outstanding result has come back
  task automatic write_reg(logic [dht_pkg::CFG_IDX_W-1:0] ridx,
                           logic [dht_pkg::CFG_DATA_W-1:0] data);
    in_ch.valid <= 1'b0;
    while (hit_select_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= ridx;
    cfg_wdata <= data;
    apply_reg(ridx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Present one transaction; the expectation is queued at acceptance
  task automatic send_item(
    logic [dht_pkg::OP_W-1:0] op, logic [dht_pkg::IDX_W-1:0] idx,
    logic signed [dht_pkg::POS_W-1:0] x, logic signed [dht_pkg::POS_W-1:0] y,
    logic [dht_pkg::RAD_W-1:0] r,
    bit typed, disk_result_t want);
    disk_result_t res;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.disk_index  <= idx;
    in_ch.pos_x       <= x;
    in_ch.pos_y       <= y;
    in_ch.disk_radius <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    res = predict_hit_select(op, idx, x, y, r);
    hit_select_due.insert(hit_select_due.size(), typed ? want : res);
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Result checking against the oldest expectation
  always @(posedge clk) begin : check_results
    disk_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (hit_select_due.size() == 0) begin
        $error("result transaction with none outstanding");
        mismatch_cnt++;
      end else begin
        exp_r = hit_select_due.pop_front();
        if (out_ch.hit !== exp_r.hit) begin
          $error("hit: expected %0d, actual %0d", exp_r.hit, out_ch.hit);
          mismatch_cnt++;
        end
        if (out_ch.hit_index !== exp_r.hit_index) begin
          $error("hit_index: expected %0d, actual %0d", exp_r.hit_index, out_ch.hit_index);
          mismatch_cnt++;
        end
        if (out_ch.selected !== exp_r.selected) begin
          $error("selected: expected %0d, actual %0d", exp_r.selected, out_ch.selected);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int n;
    int k;
    int p;
    int span;
    int t;
    logic [dht_pkg::CNT_W-1:0]        cnt;
    logic [dht_pkg::MODE_W-1:0]       md;
    logic [dht_pkg::CFG_DATA_W-1:0]   wd;
    logic [dht_pkg::OP_W-1:0]         op;
    logic [dht_pkg::IDX_W-1:0]        idx;
    logic signed [dht_pkg::POS_W-1:0] px;
    logic signed [dht_pkg::POS_W-1:0] py;
    logic [dht_pkg::RAD_W-1:0]        rad;

    gap_pct      = 0;
    stall_pct    = 0;
    shadow_count = '0;
    shadow_mode  = '0;
    for (int i = 0; i < NDISK; i++) begin
      disk_x[i] = '0;
      disk_y[i] = '0;
      disk_r[i] = '0;
      disk_loaded[i] = 1'b0;
      sel_bits[i] = 1'b0;
    end

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.op          <= '0;
    in_ch.disk_index  <= '0;
    in_ch.pos_x       <= '0;
    in_ch.pos_y       <= '0;
    in_ch.disk_radius <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: reset state, extremes, radius boundary, modes, count clearing
    add_row(item_row(dht_pkg::OP_READ, 0, 0, 0, 0, 1, 0, 0, 0));
    add_row(item_row(OP_SPARE, 63, -32768, 32767, 15'h7FFF, 1, 0, 0, 0));
    add_row(item_row(dht_pkg::OP_LOAD, 0, 0, 0, 100, 1, 0, 0, 0));
    add_row(item_row(dht_pkg::OP_LOAD, 1, 1000, 1000, 15'h7FFF, 1, 0, 0, 0));
    add_row(item_row(dht_pkg::OP_LOAD, 2, 32767, 32767, 0, 1, 0, 0, 0));
    add_row(item_row(dht_pkg::OP_LOAD, 63, -32768, -32768, 15'h7FFF, 1, 0, 0, 0));
    add_row(item_row(dht_pkg::OP_CLICK, 0, 0, 0, 0, 1, 0, 0, 0));
    add_row(cfg_row(dht_pkg::REG_DISK_COUNT, 3));
    add_row(cfg_row(dht_pkg::REG_RADIUS_MODE, dht_pkg::MODE_PER_DISK));
    add_row(item_row(dht_pkg::OP_CLICK, 0, 0, 0, 0, 1, 1, 0, 1));
    add_row(item_row(dht_pkg::OP_CLICK, 0, 99, 0, 0, 1, 1, 0, 0));
    // exactly on the edge of disk 0: falls through to disk 1
    add_row(item_row(dht_pkg::OP_CLICK, 0, 100, 0, 0, 0, 0, 0, 0));
    add_row(item_row(dht_pkg::OP_CLICK, 0, 32767, 32767, 0, 0, 0, 0, 0));
    add_row(item_row(dht_pkg::OP_CLICK, 63, -32768, -32768, 15'h7FFF, 0, 0, 0, 0));
    add_row(item_row(dht_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0, 0));
    add_row(item_row(dht_pkg::OP_READ, 3, 0, 0, 0, 1, 0, 0, 0));
    add_row(cfg_row(dht_pkg::REG_RADIUS_MODE, dht_pkg::MODE_SHARED));
    add_row(item_row(dht_pkg::OP_CLICK, 0, 1000, 1050, 0, 0, 0, 0, 0));
    add_row(cfg_row(dht_pkg::REG_RADIUS_MODE, MODE_SPARE));
    add_row(item_row(dht_pkg::OP_CLICK, 0, 0, 0, 0, 1, 0, 0, 0));
    add_row(cfg_row(dht_pkg::REG_DISK_COUNT, 1));
    add_row(cfg_row(dht_pkg::REG_RADIUS_MODE, dht_pkg::MODE_PER_DISK));
    add_row(item_row(dht_pkg::OP_READ, 1, 0, 0, 0, 1, 0, 0, 0));
    add_row(cfg_row(dht_pkg::REG_DISK_COUNT, 3));
    add_row(item_row(dht_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0, 0));
    add_row(item_row(dht_pkg::OP_CLICK, 0, 1000, 1000, 0, 0, 0, 0, 0));
    add_row(cfg_row(REG_SPARE_2, 7'h7F));
    add_row(cfg_row(REG_SPARE_3, 7'h00));
    add_row(item_row(dht_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0, 0));
    add_row(cfg_row(dht_pkg::REG_DISK_COUNT, 7'h7F));
    add_row(item_row(dht_pkg::OP_READ, 63, 0, 0, 0, 0, 0, 0, 0));
    add_row(item_row(dht_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));

    gap_pct   = 7;
    stall_pct = 7;
    foreach (directed[j]) begin
      if (directed[j].is_cfg)
        write_reg(directed[j].reg_idx, directed[j].reg_data);
      else
        send_item(directed[j].op, directed[j].idx, directed[j].x, directed[j].y,
                  directed[j].r, directed[j].typed, directed[j].want);
    end

    // Random phases, each with its own register setting and idling profile
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 53; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 53; end
        default: begin gap_pct = 7; stall_pct = 7; end
      endcase
      case (ph)
        2:       cnt = 7'd64;
        5:       cnt = 7'd127;
        7:       cnt = 7'd0;
        9:       cnt = 7'd65;
        default: cnt = dht_pkg::CNT_W'($urandom_range(1, 10));
      endcase
      if (ph % 5 == 3) md = (ph % 2) ? MODE_SPARE : MODE_NONE;
      else             md = (ph % 2) ? dht_pkg::MODE_SHARED : dht_pkg::MODE_PER_DISK;
      write_reg(dht_pkg::REG_DISK_COUNT, cnt);
      wd = dht_pkg::CFG_DATA_W'($urandom);
      wd[dht_pkg::MODE_W-1:0] = md;
      write_reg(dht_pkg::REG_RADIUS_MODE, wd);
      if (ph % 3 == 0)
        write_reg(ph % 2 ? REG_SPARE_3 : REG_SPARE_2, dht_pkg::CFG_DATA_W'($urandom));
      n = disks_in_use();

      // every disk a click may scan is loaded first
      for (int i = 0; i < NDISK; i++) begin
        if (!disk_loaded[i] && (i < n || i == 0))
          send_item(dht_pkg::OP_LOAD, i[dht_pkg::IDX_W-1:0], dht_pkg::POS_W'($urandom),
                    dht_pkg::POS_W'($urandom), pick_radius(), 0, '0);
      end

      repeat (32) begin
        p   = $urandom_range(0, 99);
        idx = dht_pkg::IDX_W'($urandom);
        px  = dht_pkg::POS_W'($urandom);
        py  = dht_pkg::POS_W'($urandom);
        rad = dht_pkg::RAD_W'($urandom);
        if (p < 15) begin
          op = dht_pkg::OP_LOAD;
          if (n > 0 && $urandom_range(0, 1)) idx = dht_pkg::IDX_W'($urandom_range(0, n - 1));
          rad = pick_radius();
        end else if (p < 70) begin
          // point in a square around a loaded disk, reaching just past its rim
          op = dht_pkg::OP_CLICK;
          if (n > 0) begin
            k = $urandom_range(0, n - 1);
            span = (shadow_mode == dht_pkg::MODE_SHARED) ? int'(disk_r[0]) : int'(disk_r[k]);
            span = span + 2;
            t = int'(disk_x[k]) + int'($urandom_range(0, 2 * span)) - span;
            px = t[dht_pkg::POS_W-1:0];
            t = int'(disk_y[k]) + int'($urandom_range(0, 2 * span)) - span;
            py = t[dht_pkg::POS_W-1:0];
          end
        end else if (p < 80) begin
          op = dht_pkg::OP_CLICK;
        end else if (p < 95) begin
          op = dht_pkg::OP_READ;
          if ($urandom_range(0, 1))
            idx = dht_pkg::IDX_W'($urandom_range(0, (n < NDISK) ? n : NDISK - 1));
        end else begin
          op = OP_SPARE;
        end
        send_item(op, idx, px, py, rad, 0, '0);
      end
    end

    // Drain
    in_ch.valid <= 1'b0;
    while (hit_select_due.size() != 0) @(posedge clk);
    repeat (5 * NDISK + 20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/dht_pkg.sv
design/dht_ifs.sv
design/dht_store.sv
design/dht_arith.sv
design/disk_hit_toggle_select.sv
bench/tb_disk_hit_toggle_select.sv
